// ===== src/rotate_convert_pixel_writer_defines.svh =====
// Assertion macros used by the top-level file to check its own logic.
`ifndef ROTATE_CONVERT_PIXEL_WRITER_DEFINES_SVH
`define ROTATE_CONVERT_PIXEL_WRITER_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define RCPW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a complete property expression.
`define RCPW_ASSERT_PROP(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) expr) \
    else $error(msg);

`endif

// ===== src/rcpw_pkg.sv =====
package rcpw_pkg;

  localparam int COORD_W     = 10;
  localparam int PROW_W      = 12;
  localparam int WIDTH_W     = 13;
  localparam int IDX_W       = 20;
  localparam int PROD_W      = 25;
  localparam int PIX_W       = 16;
  localparam int COLOR_W     = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               first_px;
    logic [PROW_W-1:0]  prow;
    logic [COORD_W-1:0] pcol;
    logic [PIX_W-1:0]   rgb;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] x2;
    logic [PROW_W-1:0]  y1;
    logic [PROW_W-1:0]  y2;
  } req_t;

  typedef struct packed {
    op_t                kind;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               dvalid;
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
  } res_t;

  // Logical column to physical row; columns past the frame land on row zero.
  function automatic logic [PROW_W-1:0] phys_row(input logic [COORD_W-1:0] col,
                                                 input logic [PROW_W-1:0] hm1);
    logic [PROW_W-1:0] c;
    c = PROW_W'(col);
    return (c > hm1) ? '0 : hm1 - c;
  endfunction

  // Logical row to physical column; rows past the frame clamp to the last column.
  function automatic logic [COORD_W-1:0] phys_col(input logic [COORD_W-1:0] row,
                                                  input logic [WIDTH_W-1:0] wm1);
    return (WIDTH_W'(row) > wm1) ? wm1[COORD_W-1:0] : row;
  endfunction

  function automatic logic [COLOR_W-1:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [COLOR_W-1:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

// ===== src/rcpw_front.sv =====
module rcpw_front #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 600
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  rcpw_pkg::op_t                       op,
  input  logic                                first_px,
  input  logic [rcpw_pkg::COORD_W-1:0]        area_left,
  input  logic [rcpw_pkg::COORD_W-1:0]        area_top,
  input  logic [rcpw_pkg::COORD_W-1:0]        area_right,
  input  logic [rcpw_pkg::COORD_W-1:0]        area_bottom,
  input  logic [rcpw_pkg::PIX_W-1:0]          pixel_rgb565,
  output rcpw_pkg::req_t                      req
);

  localparam logic [rcpw_pkg::PROW_W-1:0]  HM1 = rcpw_pkg::PROW_W'(FRAME_HEIGHT - 1);
  localparam logic [rcpw_pkg::WIDTH_W-1:0] WM1 = rcpw_pkg::WIDTH_W'(FRAME_WIDTH - 1);

  logic [rcpw_pkg::COORD_W-1:0] col_r, col_nxt;
  logic [rcpw_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [rcpw_pkg::COORD_W-1:0] left_r, left_nxt;
  logic [rcpw_pkg::COORD_W-1:0] right_r, right_nxt;
  logic [rcpw_pkg::COORD_W-1:0] eff_col, eff_row, eff_left, eff_right;
  logic                         take;

  assign take      = first_px && (op == rcpw_pkg::OP_WRITE);
  assign eff_col   = take ? area_left  : col_r;
  assign eff_row   = take ? area_top   : row_r;
  assign eff_left  = take ? area_left  : left_r;
  assign eff_right = take ? area_right : right_r;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (accept && op == rcpw_pkg::OP_WRITE) begin
      left_nxt  = eff_left;
      right_nxt = eff_right;
      if (eff_col >= eff_right) begin
        col_nxt = eff_left;
        row_nxt = eff_row + 1'b1;
      end else begin
        col_nxt = eff_col + 1'b1;
        row_nxt = eff_row;
      end
    end
  end

  always_comb begin
    req.op       = op;
    req.first_px = take;
    req.prow     = rcpw_pkg::phys_row(eff_col, HM1);
    req.pcol     = rcpw_pkg::phys_col(eff_row, WM1);
    req.rgb      = pixel_rgb565;
    req.x1       = rcpw_pkg::phys_col(area_top, WM1);
    req.x2       = rcpw_pkg::phys_col(area_bottom, WM1);
    req.y1       = rcpw_pkg::phys_row(area_right, HM1);
    req.y2       = rcpw_pkg::phys_row(area_left, HM1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

// ===== src/rcpw_fifo.sv =====
module rcpw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rcpw_pkg::req_t din,
  output logic           full,
  input  logic           pop,
  output rcpw_pkg::req_t dout,
  output logic           empty
);

  rcpw_pkg::req_t                  mem_r [rcpw_pkg::QUEUE_DEPTH];
  logic [rcpw_pkg::QPTR_W-1:0]     wr_r, wr_nxt;
  logic [rcpw_pkg::QPTR_W-1:0]     rd_r, rd_nxt;
  logic [rcpw_pkg::QPTR_W:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (rcpw_pkg::QPTR_W+1)'(rcpw_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// ===== src/rcpw_back.sv =====
module rcpw_back #(
  parameter int FRAME_WIDTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  rcpw_pkg::req_t q_data,
  output logic           q_pop,
  input  logic           out_ready,
  output logic           out_valid,
  output rcpw_pkg::res_t res
);

  localparam logic [rcpw_pkg::WIDTH_W-1:0] FW = rcpw_pkg::WIDTH_W'(FRAME_WIDTH);

  logic                          out_valid_r, out_valid_nxt;
  rcpw_pkg::res_t                res_r, res_nxt;
  logic                          dflag_r, dflag_nxt;
  logic [rcpw_pkg::COORD_W-1:0]  xmin_r, xmin_nxt, xmax_r, xmax_nxt;
  logic [rcpw_pkg::PROW_W-1:0]   ymin_r, ymin_nxt, ymax_r, ymax_nxt;
  logic [rcpw_pkg::PROD_W-1:0]   prod, sum;

  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign prod = rcpw_pkg::PROD_W'(q_data.prow) * rcpw_pkg::PROD_W'(FW);
  assign sum  = prod + rcpw_pkg::PROD_W'(q_data.pcol);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    dflag_nxt     = dflag_r;
    xmin_nxt      = xmin_r;
    ymin_nxt      = ymin_r;
    xmax_nxt      = xmax_r;
    ymax_nxt      = ymax_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      res_nxt.kind  = q_data.op;
      if (q_data.op == rcpw_pkg::OP_REPORT) begin
        res_nxt.dvalid = dflag_r;
        if (dflag_r) begin
          res_nxt.x_min = xmin_r;
          res_nxt.y_min = ymin_r[rcpw_pkg::COORD_W-1:0];
          res_nxt.x_max = xmax_r;
          res_nxt.y_max = ymax_r[rcpw_pkg::COORD_W-1:0];
        end
        dflag_nxt = 1'b0;
      end else begin
        res_nxt.idx   = sum[rcpw_pkg::IDX_W-1:0];
        res_nxt.red   = rcpw_pkg::expand5(q_data.rgb[15:11]);
        res_nxt.green = rcpw_pkg::expand6(q_data.rgb[10:5]);
        res_nxt.blue  = rcpw_pkg::expand5(q_data.rgb[4:0]);
        if (q_data.first_px) begin
          dflag_nxt = 1'b1;
          if (!dflag_r) begin
            xmin_nxt = q_data.x1;
            ymin_nxt = q_data.y1;
            xmax_nxt = q_data.x2;
            ymax_nxt = q_data.y2;
          end else begin
            if (q_data.x1 < xmin_r) xmin_nxt = q_data.x1;
            if (q_data.y1 < ymin_r) ymin_nxt = q_data.y1;
            if (q_data.x2 > xmax_r) xmax_nxt = q_data.x2;
            if (q_data.y2 > ymax_r) ymax_nxt = q_data.y2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dflag_r     <= 1'b0;
      xmin_r      <= '0;
      ymin_r      <= '0;
      xmax_r      <= '0;
      ymax_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      dflag_r     <= dflag_nxt;
      xmin_r      <= xmin_nxt;
      ymin_r      <= ymin_nxt;
      xmax_r      <= xmax_nxt;
      ymax_r      <= ymax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ===== src/rotate_convert_pixel_writer.sv =====
// Converts RGB565 pixels of portrait areas to RGB888 and emits framebuffer writes at the
// pixel index turned 90 degrees into a landscape frame, while tracking the union of the
// turned areas as a dirty rectangle that a report request returns and clears. Every request,
// write or report, gives exactly one result. The block takes one request per clock cycle
// while the queue is not full; a request is stored in a four-entry queue and then registered
// as a result. The queue, between the cursor logic at the input and the index multiplier and
// dirty tracker at the output, takes up to four requests while the result side is stalled.
`include "rotate_convert_pixel_writer_defines.svh"

module rotate_convert_pixel_writer #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 600
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // area_left, area_top, area_right, area_bottom, pixel_rgb565
  input  logic [55:0] in_tdata,
  // opcode, first_of_area
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // fb_pixel_index, red, green, blue, dirty_valid, dirty_x_min, dirty_y_min,
  // dirty_x_max, dirty_y_max, zero fill
  output logic [87:0] out_tdata,
  // result_kind
  output logic [0:0]  out_tuser
);

  rcpw_pkg::req_t req, q_data;
  rcpw_pkg::res_t res;
  logic           q_full, q_empty, q_pop, in_acc;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  rcpw_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_acc),
    .op           (rcpw_pkg::op_t'(in_tuser[0])),
    .first_px     (in_tuser[1]),
    .area_left    (in_tdata[9:0]),
    .area_top     (in_tdata[19:10]),
    .area_right   (in_tdata[29:20]),
    .area_bottom  (in_tdata[39:30]),
    .pixel_rgb565 (in_tdata[55:40]),
    .req          (req)
  );

  rcpw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .din   (req),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  rcpw_back #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .res       (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {3'b000, res.y_max, res.x_max, res.y_min, res.x_min, res.dvalid,
                      res.blue, res.green, res.red, res.idx};

  `RCPW_ASSERT_PROP(a_fall_through, in_acc && q_empty && !out_tvalid |=> ##1 out_tvalid, "request did not reach the output two cycles after an idle accept")
  `RCPW_ASSERT_IMPL(a_write_clean, out_tvalid && out_tuser == rcpw_pkg::OP_WRITE, out_tdata[84:44] == '0, "write result carries dirty rectangle bits")
  `RCPW_ASSERT_IMPL(a_empty_report, out_tvalid && out_tuser == rcpw_pkg::OP_REPORT && !out_tdata[44], out_tdata[84:45] == '0 && out_tdata[43:0] == '0, "empty report carries nonzero fields")

endmodule
